### sv/sffa_pkg.sv
// Package for the segment first-fit allocator: field structs, codes, sizes.
// No dependencies.
`timescale 1ns / 1ps

package sffa_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int PAGE_BYTES   = 4096;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = 7;
    localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
    localparam int PAGES_W      = 21;
    localparam int ADDR_W       = 32;
    localparam int ENTRY_W      = ADDR_W + PAGES_W + 1;

    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_ALLOC   = 2'd1;
    localparam logic [1:0] ACT_RESERVE = 2'd2;
    localparam logic [1:0] ACT_FREE    = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_ZERO  = 2'd3;

    typedef struct packed {
        logic [1:0]         action;
        logic [ADDR_W-1:0]  address;
        logic [PAGES_W-1:0] pages;
        logic [ADDR_W-1:0]  region_bytes;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] result_address;
        logic [CNT_W-1:0]  segment_count;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  base;
        logic [PAGES_W-1:0] pages;
        logic               free;
    } entry_t;

endpackage

### sv/segment_first_fit_allocator.sv
// Top level of the segment first-fit allocator.
// Depends on sffa_pkg and sffa_ram.
`timescale 1ns / 1ps

// The segment table lives in one RAM (base, pages, free per entry) with a
// registered read. One transaction is handled at a time, and the input is
// stalled while a result waits on a stalled output. A request other than a
// load scans entries from index 0, reading then checking each entry, until
// it finds its match. Inserting k slots then shifts the tail up by k, and a
// merge on free shifts the tail down the same way. A load shifts the whole
// table up by one and writes its segment at the front. No clearing pass is
// needed after reset: only entries below the count are ever read.
module segment_first_fit_allocator (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  sffa_pkg::req_t  in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output sffa_pkg::rsp_t  out_data
);
    import sffa_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_PREV_RD, S_PREV_CHK,
        S_NEXT_RD, S_NEXT_CHK, S_SHUP_RD, S_SHUP_WR, S_SHDN_RD, S_SHDN_WR,
        S_WRITE0, S_WRITE1, S_WRITE2, S_DONE
    } state_t;

    state_t                state_reg;
    req_t                  req_reg;
    rsp_t                  rsp_reg;
    logic                  out_valid_reg;
    logic [CNT_W-1:0]      total_reg;
    logic [IDX_W:0]        idx_reg;     // scan index / shift pointer
    logic [IDX_W:0]        pos_reg;     // matched entry index
    logic [IDX_W:0]        lim_reg;     // shift bound
    logic [1:0]            gap_reg;     // shift distance
    entry_t                cur_reg;     // matched entry
    logic                  mprev_reg;
    logic [1:0]            wcnt_reg;    // entries to write after a shift
    entry_t                w_reg [3];   // pieces to write at pos..pos+2
    logic [ADDR_W-1:0]     res_reg;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    entry_t                ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    entry_t                ram_rdata;

    sffa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_SEGMENTS)) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Wide address arithmetic on the current entry; segment ends need 34 bits
    localparam int EW = ADDR_W + 2;
    logic [EW-1:0]      cur_end, req_stop, req_addr_w;
    logic [PAGES_W-1:0] lead_pages;
    logic [EW-1:0]      prv_end;
    logic [PAGES_W:0]   sum_prev, sum_next;
    logic [ADDR_W-1:0]  ld_pages_raw;
    logic [PAGES_W-1:0] ld_pages;
    logic               need_lead, need_tail;
    logic [1:0]         need;
    logic [ADDR_W-1:0]  lead_bytes;

    always_comb
    begin
        cur_end    = EW'(ram_rdata.base) + (EW'(ram_rdata.pages) << PAGE_SHIFT);
        req_addr_w = (req_reg.action == ACT_ALLOC) ? EW'(ram_rdata.base)
                                                   : EW'(req_reg.address);
        req_stop   = req_addr_w + (EW'(req_reg.pages) << PAGE_SHIFT);
        lead_bytes = req_addr_w[ADDR_W-1:0] - ram_rdata.base;
        lead_pages = PAGES_W'(lead_bytes >> PAGE_SHIFT);
        need_lead  = req_addr_w > EW'(ram_rdata.base);
        need_tail  = req_stop < cur_end;
        need       = 2'(need_lead) + 2'(need_tail);
        prv_end    = EW'(ram_rdata.base) + (EW'(ram_rdata.pages) << PAGE_SHIFT);
        sum_prev   = {1'b0, ram_rdata.pages} + {1'b0, cur_reg.pages};
        sum_next   = {1'b0, cur_reg.pages} + {1'b0, ram_rdata.pages};
        ld_pages_raw = req_reg.region_bytes >> PAGE_SHIFT;
        ld_pages   = (ld_pages_raw > ADDR_W'({PAGES_W{1'b1}}))
                     ? {PAGES_W{1'b1}} : ld_pages_raw[PAGES_W-1:0];
    end

    // RAM port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = idx_reg[IDX_W-1:0];
        case (state_reg)
            S_SHUP_RD:
            begin
                // fetch the entry just below the pointer
                ram_raddr = IDX_W'(idx_reg - 1'b1);
            end
            S_SHUP_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(idx_reg + (IDX_W+1)'(gap_reg));
                ram_wdata = ram_rdata;
            end
            S_SHDN_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(idx_reg - (IDX_W+1)'(gap_reg));
                ram_wdata = ram_rdata;
            end
            S_WRITE0, S_WRITE1, S_WRITE2:
            begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(pos_reg);
                ram_wdata = w_reg[0];
            end
            default: ;
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && !(out_valid_reg && out_stall))
                    begin
                        out_valid_reg <= 1'b0;
                        req_reg       <= in_data;
                        idx_reg       <= '0;
                        res_reg       <= '0;
                        rsp_reg.status <= ST_NOFIT;
                        state_reg     <= S_SCAN_RD;
                        if (in_data.action == ACT_LOAD)
                        begin
                            state_reg <= S_DONE;
                            if ((in_data.region_bytes >> PAGE_SHIFT) == '0)
                            begin
                                rsp_reg.status <= ST_ZERO;
                            end
                            else if (32'(total_reg) >= 32'(MAX_SEGMENTS))
                            begin
                                rsp_reg.status <= ST_FULL;
                            end
                            else
                            begin
                                // shift everything up by one, then write front
                                pos_reg   <= '0;
                                gap_reg   <= 2'd1;
                                idx_reg   <= (IDX_W+1)'(total_reg);
                                lim_reg   <= '0;
                                wcnt_reg  <= 2'd1;
                                state_reg <= S_SHUP_RD;
                            end
                        end
                        else if (in_data.action != ACT_FREE && in_data.pages == '0)
                        begin
                            rsp_reg.status <= ST_ZERO;
                            state_reg      <= S_DONE;
                        end
                    end
                    else if (out_valid_reg && !out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end

                S_SCAN_RD:
                begin
                    if (idx_reg >= (IDX_W+1)'(total_reg))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_SCAN_CHK;
                    end
                end

                S_SCAN_CHK:
                begin
                    state_reg <= S_SCAN_RD;
                    idx_reg   <= idx_reg + 1'b1;
                    cur_reg   <= ram_rdata;
                    pos_reg   <= idx_reg;
                    case (req_reg.action)
                        ACT_FREE:
                        begin
                            if (ram_rdata.base == req_reg.address)
                            begin
                                rsp_reg.status <= ST_OK;
                                res_reg        <= req_reg.address;
                                if (ram_rdata.free)
                                begin
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    cur_reg.free <= 1'b1;
                                    mprev_reg    <= 1'b0;
                                    // first entry has no previous neighbour
                                    if (idx_reg == '0)
                                    begin
                                        idx_reg   <= (IDX_W+1)'(1);
                                        state_reg <= S_NEXT_RD;
                                    end
                                    else
                                    begin
                                        idx_reg   <= idx_reg - 1'b1;
                                        state_reg <= S_PREV_RD;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            logic hit;
                            logic fits;
                            hit  = 1'b0;
                            fits = 1'b0;
                            if (req_reg.action == ACT_ALLOC)
                            begin
                                hit  = ram_rdata.free && (ram_rdata.pages >= req_reg.pages);
                                fits = hit;
                            end
                            else
                            begin
                                hit  = ram_rdata.free
                                       && (EW'(req_reg.address) >= EW'(ram_rdata.base))
                                       && (EW'(req_reg.address) <= cur_end);
                                fits = req_stop <= cur_end;
                            end
                            if (hit)
                            begin
                                state_reg <= S_DONE;
                                if (fits)
                                begin
                                    if (32'(total_reg) + 32'(need) > 32'(MAX_SEGMENTS))
                                    begin
                                        rsp_reg.status <= ST_FULL;
                                    end
                                    else
                                    begin
                                        rsp_reg.status <= ST_OK;
                                        res_reg        <= req_addr_w[ADDR_W-1:0];
                                        // pieces in table order
                                        if (need_lead)
                                        begin
                                            w_reg[0] <= '{ram_rdata.base, lead_pages, 1'b1};
                                            w_reg[1] <= '{req_addr_w[ADDR_W-1:0],
                                                          req_reg.pages, 1'b0};
                                            w_reg[2] <= '{req_stop[ADDR_W-1:0],
                                                PAGES_W'(ram_rdata.pages - lead_pages
                                                         - req_reg.pages), 1'b1};
                                        end
                                        else
                                        begin
                                            w_reg[0] <= '{req_addr_w[ADDR_W-1:0],
                                                          req_reg.pages, 1'b0};
                                            w_reg[1] <= '{req_stop[ADDR_W-1:0],
                                                PAGES_W'(ram_rdata.pages - req_reg.pages),
                                                1'b1};
                                            w_reg[2] <= '0;
                                        end
                                        wcnt_reg <= 2'd1 + need;
                                        gap_reg  <= need;
                                        idx_reg  <= (IDX_W+1)'(total_reg);
                                        lim_reg  <= idx_reg + 1'b1;
                                        state_reg <= (need == 2'd0) ? S_WRITE0 : S_SHUP_RD;
                                    end
                                end
                            end
                        end
                    endcase
                end

                // previous neighbour check on free
                S_PREV_RD:
                begin
                    state_reg <= S_PREV_CHK;
                end

                S_PREV_CHK:
                begin
                    if (ram_rdata.free && prv_end == EW'(cur_reg.base)
                        && !sum_prev[PAGES_W])
                    begin
                        cur_reg.base  <= ram_rdata.base;
                        cur_reg.pages <= sum_prev[PAGES_W-1:0];
                        mprev_reg     <= 1'b1;
                        pos_reg       <= pos_reg - 1'b1;
                        idx_reg       <= pos_reg + 1'b1;
                    end
                    else
                    begin
                        idx_reg <= pos_reg + 1'b1;
                    end
                    state_reg <= S_NEXT_RD;
                end

                S_NEXT_RD:
                begin
                    if (idx_reg >= (IDX_W+1)'(total_reg))
                    begin
                        // no next neighbour
                        w_reg[0] <= cur_reg;
                        wcnt_reg <= 2'd1;
                        if (mprev_reg)
                        begin
                            gap_reg   <= 2'd1;
                            idx_reg   <= pos_reg + 2'd2;
                            state_reg <= S_SHDN_RD;
                        end
                        else
                        begin
                            state_reg <= S_WRITE0;
                        end
                    end
                    else
                    begin
                        state_reg <= S_NEXT_CHK;
                    end
                end

                S_NEXT_CHK:
                begin
                    wcnt_reg <= 2'd1;
                    if (ram_rdata.free
                        && (EW'(cur_reg.base) + (EW'(cur_reg.pages) << PAGE_SHIFT))
                           == EW'(ram_rdata.base)
                        && !sum_next[PAGES_W])
                    begin
                        w_reg[0] <= '{cur_reg.base, sum_next[PAGES_W-1:0], 1'b1};
                        gap_reg  <= mprev_reg ? 2'd2 : 2'd1;
                        idx_reg  <= idx_reg + 1'b1;
                        state_reg <= S_SHDN_RD;
                    end
                    else
                    begin
                        w_reg[0] <= cur_reg;
                        if (mprev_reg)
                        begin
                            gap_reg   <= 2'd1;
                            state_reg <= S_SHDN_RD;
                        end
                        else
                        begin
                            state_reg <= S_WRITE0;
                        end
                    end
                end

                // move tail up: entries [lim, total) to +gap, highest first
                S_SHUP_RD:
                begin
                    if (idx_reg == lim_reg)
                    begin
                        total_reg <= total_reg + CNT_W'(gap_reg);
                        if (req_reg.action == ACT_LOAD)
                        begin
                            w_reg[0] <= '{req_reg.address, ld_pages, 1'b1};
                            rsp_reg.status <= ST_OK;
                            res_reg   <= req_reg.address;
                        end
                        state_reg <= S_WRITE0;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg - 1'b1;
                        state_reg <= S_SHUP_WR;
                    end
                end

                S_SHUP_WR:
                begin
                    state_reg <= S_SHUP_RD;
                end

                // move tail down: entries [idx, total) to -gap
                S_SHDN_RD:
                begin
                    if (idx_reg >= (IDX_W+1)'(total_reg))
                    begin
                        total_reg <= total_reg - CNT_W'(gap_reg);
                        state_reg <= S_WRITE0;
                    end
                    else
                    begin
                        state_reg <= S_SHDN_WR;
                    end
                end

                S_SHDN_WR:
                begin
                    idx_reg   <= idx_reg + 1'b1;
                    state_reg <= S_SHDN_RD;
                end

                // write pieces at pos, pos+1, pos+2
                S_WRITE0, S_WRITE1, S_WRITE2:
                begin
                    pos_reg  <= pos_reg + 1'b1;
                    w_reg[0] <= w_reg[1];
                    w_reg[1] <= w_reg[2];
                    wcnt_reg <= wcnt_reg - 1'b1;
                    state_reg <= (wcnt_reg == 2'd1) ? S_DONE
                               : (state_reg == S_WRITE0) ? S_WRITE1 : S_WRITE2;
                end

                S_DONE:
                begin
                    rsp_reg.result_address <= (rsp_reg.status == ST_OK) ? res_reg : '0;
                    rsp_reg.segment_count  <= total_reg;
                    out_valid_reg          <= 1'b1;
                    state_reg              <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### sv/sffa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module sffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### verif/tb_segment_first_fit_allocator.sv
// Testbench for segment_first_fit_allocator: directed and random table actions,
// checked against a behavioral segment table. Depends on sffa_pkg and the RTL.
`timescale 1ns / 1ps

module tb_segment_first_fit_allocator;
    import sffa_pkg::*;

    localparam longint PG_MAX = 64'h1FFFFF;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int HOLD_CYCLES = 400;

    // Holds the mirrored segment table and the queue of predicted responses.
    class seg_scoreboard;
        logic [31:0] seg_base [MAX_SEGMENTS];
        logic [20:0] seg_pages [MAX_SEGMENTS];
        bit          seg_free [MAX_SEGMENTS];
        int          seg_total;
        rsp_t        pending_rsp [$];
        int          mismatches;

        function new();
            seg_total = 0;
            mismatches = 0;
        endfunction

        function longint seg_end(int i);
            return longint'(seg_base[i]) + longint'(seg_pages[i]) * PAGE_BYTES;
        endfunction

        function void open_at(int pos);
            for (int j = seg_total; j > pos; j--)
            begin
                seg_base[j] = seg_base[j-1];
                seg_pages[j] = seg_pages[j-1];
                seg_free[j] = seg_free[j-1];
            end
            seg_total++;
        endfunction

        function void close_at(int pos);
            for (int j = pos; j < seg_total - 1; j++)
            begin
                seg_base[j] = seg_base[j+1];
                seg_pages[j] = seg_pages[j+1];
                seg_free[j] = seg_free[j+1];
            end
            seg_total--;
        endfunction

        function void set_entry(int pos, longint b, longint p, bit f);
            seg_base[pos] = b[31:0];
            seg_pages[pos] = p[20:0];
            seg_free[pos] = f;
        endfunction

        // Split segment i around [addr, addr+pg pages); returns base or flags full.
        function void fit(int i, longint addr, longint pg,
                          output logic [1:0] st, output logic [31:0] res);
            longint b, e, stop, lead, old;
            int k;
            b = seg_base[i];
            e = seg_end(i);
            stop = addr + pg * PAGE_BYTES;
            lead = (addr - b) / PAGE_BYTES;
            old = seg_pages[i];
            k = (addr > b) + (stop < e);
            if (seg_total + k > MAX_SEGMENTS)
            begin
                st = ST_FULL;
                res = 0;
                return;
            end
            if (addr > b)
            begin
                open_at(i);
                set_entry(i, b, lead, 1);
                i++;
            end
            if (stop < e)
            begin
                open_at(i + 1);
                set_entry(i + 1, stop, old - (lead + pg), 1);
            end
            set_entry(i, addr, pg, 0);
            st = ST_OK;
            res = seg_base[i];
        endfunction

        function void merge_around(int i);
            if (i > 0 && seg_free[i-1] && seg_end(i-1) == longint'(seg_base[i]) &&
                longint'(seg_pages[i-1]) + seg_pages[i] <= PG_MAX)
            begin
                seg_base[i] = seg_base[i-1];
                seg_pages[i] = seg_pages[i] + seg_pages[i-1];
                close_at(i - 1);
                i--;
            end
            if (i + 1 < seg_total && seg_free[i+1] &&
                seg_end(i) == longint'(seg_base[i+1]) &&
                longint'(seg_pages[i]) + seg_pages[i+1] <= PG_MAX)
            begin
                seg_pages[i] = seg_pages[i] + seg_pages[i+1];
                close_at(i + 1);
            end
        endfunction

        // Apply one accepted request and queue its response.
        function void note_request(req_t rq);
            logic [1:0] st;
            logic [31:0] res;
            longint np, a, pg;
            rsp_t r;
            st = ST_NOFIT;
            res = 0;
            a = rq.address;
            pg = rq.pages;
            case (rq.action)
                ACT_LOAD:
                begin
                    np = longint'(rq.region_bytes) / PAGE_BYTES;
                    if (np > PG_MAX) np = PG_MAX;
                    if (np == 0) st = ST_ZERO;
                    else if (seg_total >= MAX_SEGMENTS) st = ST_FULL;
                    else
                    begin
                        open_at(0);
                        set_entry(0, a, np, 1);
                        st = ST_OK;
                        res = rq.address;
                    end
                end
                ACT_ALLOC:
                begin
                    if (pg == 0) st = ST_ZERO;
                    else
                        for (int i = 0; i < seg_total; i++)
                            if (seg_free[i] && seg_pages[i] >= pg)
                            begin
                                fit(i, seg_base[i], pg, st, res);
                                break;
                            end
                end
                ACT_RESERVE:
                begin
                    if (pg == 0) st = ST_ZERO;
                    else
                        for (int i = 0; i < seg_total; i++)
                        begin
                            if (!seg_free[i]) continue;
                            if (a >= longint'(seg_base[i]) && a <= seg_end(i))
                            begin
                                if (a + pg * PAGE_BYTES <= seg_end(i))
                                    fit(i, a, pg, st, res);
                                break;
                            end
                        end
                end
                default:
                begin
                    for (int i = 0; i < seg_total; i++)
                        if (seg_base[i] == rq.address)
                        begin
                            if (!seg_free[i])
                            begin
                                seg_free[i] = 1;
                                merge_around(i);
                            end
                            st = ST_OK;
                            res = rq.address;
                            break;
                        end
                end
            endcase
            if (st != ST_OK) res = 0;
            r.status = st;
            r.result_address = res;
            r.segment_count = seg_total[6:0];
            pending_rsp.push_back(r);
        endfunction

        function void check_response(rsp_t got);
            rsp_t exp_r;
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response %h", got);
                return;
            end
            exp_r = pending_rsp.pop_front();
            if (got.status !== exp_r.status || got.result_address !== exp_r.result_address ||
                got.segment_count !== exp_r.segment_count)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp st=%0d addr=%h cnt=%0d got st=%0d addr=%h cnt=%0d",
                             exp_r.status, exp_r.result_address, exp_r.segment_count,
                             got.status, got.result_address, got.segment_count);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    req_t in_data = '0;
    logic out_valid;
    logic out_stall = 0;
    rsp_t out_data;

    seg_scoreboard sb = new();
    int cycle_count = 0;
    bit hold_req = 0;
    logic [31:0] handed_out [$];

    segment_first_fit_allocator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Monitor both channels at the edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_request(in_data);
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_response(out_data);
            if (out_data.status == ST_OK && out_data.result_address != 0)
                handed_out.push_back(out_data.result_address);
        end
    end

    function int gap_len();
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 9) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random stalls, plus one long hold-off once requested
    initial
    begin
        int g;
        bit held;
        held = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !held)
            begin
                held = 1;
                out_stall <= 1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 0;
            end
            else
            begin
                g = gap_len();
                if (g == 0)
                begin
                    out_stall <= 0;
                end
                else
                begin
                    out_stall <= 1;
                    repeat (g) @(posedge clk);
                    out_stall <= 0;
                end
            end
        end
    end

    // Offer one transaction, holding it until accepted
    task automatic send(req_t rq, bit gaps);
        int g;
        in_data <= rq;
        in_valid <= 1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        g = gaps ? gap_len() : 0;
        if (g != 0)
        begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
    endtask

    function req_t mk(logic [1:0] act, logic [31:0] a, logic [20:0] p, logic [31:0] b);
        req_t r;
        r.action = act;
        r.address = a;
        r.pages = p;
        r.region_bytes = b;
        return r;
    endfunction

    function logic [31:0] page_addr();
        return {20'($urandom_range(0, 32'hFFFFF)), 12'h000};
    endfunction

    // Mostly well-formed actions against what was loaded and handed out
    function req_t random_req();
        int sel;
        logic [31:0] a;
        sel = $urandom_range(0, 99);
        if (sel < 12)
            return mk(ACT_LOAD, {8'($urandom_range(0, 255)), 24'h0}, 21'($urandom),
                      $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 64) * PAGE_BYTES);
        if (sel < 45)
            return mk(ACT_ALLOC, $urandom, $urandom_range(0, 9) == 0 ? 21'($urandom) :
                      21'($urandom_range(0, 16)), $urandom);
        if (sel < 60)
        begin
            a = {8'($urandom_range(0, 255)), 24'h0} + 32'($urandom_range(0, 80) * PAGE_BYTES);
            if ($urandom_range(0, 4) == 0) a = a + 32'($urandom_range(1, 4095));
            if ($urandom_range(0, 19) == 0) a = $urandom;
            return mk(ACT_RESERVE, a, 21'($urandom_range(0, 8)), $urandom);
        end
        if (sel < 95 && handed_out.size() > 0)
        begin
            int k;
            k = $urandom_range(0, handed_out.size() - 1);
            a = handed_out[k];
            handed_out.delete(k);
            return mk(ACT_FREE, a, 21'($urandom), $urandom);
        end
        return mk(ACT_FREE, $urandom_range(0, 1) ? $urandom : page_addr(), 21'($urandom),
                  $urandom);
    endfunction

    initial
    begin
        int drain;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: empty table, extremes, splits, merges
        send(mk(ACT_ALLOC, 32'h0, 21'd1, 32'h0), 0);
        send(mk(ACT_FREE, 32'h0, 21'd0, 32'h0), 0);
        send(mk(ACT_LOAD, 32'h1000, 21'd0, 32'd4095), 0);
        send(mk(ACT_LOAD, 32'hFFFF_F000, 21'h1FFFFF, 32'hFFFF_FFFF), 0);
        send(mk(ACT_LOAD, 32'h0010_0000, 21'd0, 32'h0001_0000), 0);
        send(mk(ACT_ALLOC, 32'h0, 21'd0, 32'h0), 0);
        send(mk(ACT_RESERVE, 32'h0010_2000, 21'd0, 32'h0), 0);
        send(mk(ACT_ALLOC, 32'hFFFF_FFFF, 21'h1FFFFF, 32'h0), 0);
        send(mk(ACT_ALLOC, 32'h0, 21'd3, 32'h0), 0);
        send(mk(ACT_RESERVE, 32'h0010_8800, 21'd2, 32'h0), 0);
        send(mk(ACT_RESERVE, 32'h0010_5000, 21'd20, 32'h0), 0);
        send(mk(ACT_RESERVE, 32'h0011_0000, 21'd1, 32'h0), 0);
        send(mk(ACT_FREE, 32'h0010_8800, 21'd0, 32'h0), 0);
        send(mk(ACT_FREE, 32'h0010_8800, 21'd0, 32'h0), 0);
        send(mk(ACT_FREE, 32'h0010_0000, 21'd0, 32'h0), 0);
        send(mk(ACT_FREE, 32'h1234_5678, 21'd0, 32'h0), 0);
        send(mk(ACT_ALLOC, 32'h0, 21'h1FFFFF, 32'h0), 0);
        send(mk(ACT_FREE, 32'hFFFF_F000, 21'd0, 32'h0), 0);
        // Fill the table to the limit with one-page loads
        for (int i = 0; i < 66; i++)
            send(mk(ACT_LOAD, 32'h4000_0000 + i * 32'h2000, 21'd0, PAGE_BYTES), 0);
        send(mk(ACT_ALLOC, 32'h0, 21'd1, 32'h0), 0);
        send(mk(ACT_RESERVE, 32'hFFFF_F800, 21'd1, 32'h0), 0);

        // Random part; long receiver hold-off early on
        for (int n = 0; n < 900; n++)
        begin
            if (n == 100) hold_req = 1;
            send(random_req(), n > 300 || n < 100);
            // Reset the table by freeing everything occasionally is not possible;
            // instead rely on frees to keep it from staying full.
        end
        in_valid <= 0;

        drain = 0;
        while (sb.pending_rsp.size() != 0 && drain < 100000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (300) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_rsp.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
